@@ hw/rtl/fsrb_pkg.sv @@
// Shared types and constants for the flagged slot ring buffer.
package fsrb_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;
  localparam int CFG_W      = 5;
  localparam int OVR_W      = 32;

  localparam logic [CFG_W-1:0] SLOT_COUNT_RST = CFG_W'(16);

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_WRITE   = 2'd1,
    OP_CONFIRM = 2'd2,
    OP_READ    = 2'd3
  } fsrb_op_t;

  // Work request from the datapath to the slot controller.
  typedef struct packed {
    logic     fire;
    fsrb_op_t op;
  } fsrb_ctrl_t;

  // Outcome of one operation as seen by the datapath.
  typedef struct packed {
    logic status;
    logic read_ok;
  } fsrb_stat_t;

endpackage

@@ hw/rtl/fsrb_if.sv @@
// Channel interfaces: request, response and slot count configuration.
interface fsrb_req_if import fsrb_pkg::*; #(
  parameter int DATA_WIDTH = DATA_W_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            operation;
  logic [DATA_WIDTH-1:0] write_data;

  modport source (output valid, output operation, output write_data, input ready);
  modport sink   (input valid, input operation, input write_data, output ready);
endinterface

interface fsrb_rsp_if import fsrb_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_W_DEF
) ();
  localparam int IDX_W = $clog2(DEPTH);

  logic                  valid;
  logic                  ready;
  logic                  status;
  logic [DATA_WIDTH-1:0] read_data;
  logic [IDX_W-1:0]      write_slot;
  logic [OVR_W-1:0]      overrun_count;

  modport source (output valid, output status, output read_data, output write_slot,
                  output overrun_count, input ready);
  modport sink   (input valid, input status, input read_data, input write_slot,
                  input overrun_count, output ready);
endinterface

interface fsrb_cfg_if import fsrb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] slot_count;

  modport source (output valid, output slot_count, input ready);
  modport sink   (input valid, input slot_count, output ready);
endinterface

@@ hw/rtl/fsrb_store.sv @@
// Slot data memory with per-slot written bits and a prefetched read word.
module fsrb_store import fsrb_pkg::*; #(
  parameter  int DEPTH      = DEPTH_DEF,
  parameter  int DATA_WIDTH = DATA_W_DEF,
  localparam int IDX_W      = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [DATA_WIDTH-1:0] rd_word
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0]      written;
  logic [DATA_WIDTH-1:0] mem_q;
  logic                  vld_q;
  logic                  bypass;

  // The read address is the read slot for the next cycle, so a write to that
  // same slot in this cycle has to be forwarded around the memory.
  assign bypass = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= bypass ? wr_data : mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      vld_q <= bypass | written[rd_addr];
    end
  end

  // A slot never written reads as zero.
  assign rd_word = vld_q ? mem_q : '0;

endmodule

@@ hw/rtl/fsrb_ctrl.sv @@
// Slot flags, write and read pointers, overrun counter and slot count register.
module fsrb_ctrl import fsrb_pkg::*; #(
  parameter  int DEPTH = DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  fsrb_ctrl_t       ctrl,
  output fsrb_stat_t       stat,
  output logic [IDX_W-1:0] wr_index,
  output logic [IDX_W-1:0] wr_index_next,
  output logic [IDX_W-1:0] rd_index_next,
  output logic [OVR_W-1:0] overruns_next
);

  localparam int NW = (CFG_W > IDX_W + 1) ? CFG_W : IDX_W + 1;
  localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);

  logic [CFG_W-1:0] slot_count;
  logic [DEPTH-1:0] full;
  logic [DEPTH-1:0] full_next;
  logic [IDX_W-1:0] rd_index;
  logic             armed;
  logic             armed_next;
  logic [OVR_W-1:0] overruns;
  logic [NW-1:0]    count_ext;
  logic [NW-1:0]    used;
  logic [IDX_W-1:0] nxt_w;
  logic [IDX_W-1:0] nxt_r;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx,
                                                 input logic [NW-1:0] lim);
    logic [NW-1:0] n;
    n = NW'(idx) + NW'(1);
    return (n >= lim) ? '0 : n[IDX_W-1:0];
  endfunction

  // A zero count acts as one slot; a count above the ring size saturates.
  assign count_ext = NW'(slot_count);
  assign used = (count_ext == '0) ? NW'(1) :
                (count_ext > DEPTH_N) ? DEPTH_N : count_ext;

  assign nxt_w = next_slot(wr_index, used);
  assign nxt_r = next_slot(rd_index, used);

  always_comb begin
    full_next     = full;
    wr_index_next = wr_index;
    rd_index_next = rd_index;
    armed_next    = armed;
    overruns_next = overruns;
    stat          = '0;
    if (ctrl.fire) begin
      unique case (ctrl.op)
        OP_ACQUIRE: begin
          // The first acquire fixes where the read side starts.
          if (!armed) begin
            rd_index_next = wr_index;
            armed_next    = 1'b1;
          end
          if (!full[nxt_w]) begin
            full_next[wr_index] = 1'b1;
            wr_index_next       = nxt_w;
          end else begin
            full_next[wr_index] = 1'b0;
            overruns_next       = overruns + OVR_W'(1);
          end
        end
        OP_WRITE: begin
        end
        OP_CONFIRM: begin
          full_next[wr_index] = 1'b1;
        end
        OP_READ: begin
          if (armed && full[rd_index]) begin
            full_next[rd_index] = 1'b0;
            rd_index_next       = nxt_r;
            stat.read_ok        = 1'b1;
          end else begin
            stat.status = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= SLOT_COUNT_RST;
      full       <= '0;
      wr_index   <= '0;
      rd_index   <= '0;
      armed      <= 1'b0;
      overruns   <= '0;
    end else begin
      if (cfg_we) begin
        slot_count <= cfg_data;
      end
      full     <= full_next;
      wr_index <= wr_index_next;
      rd_index <= rd_index_next;
      armed    <= armed_next;
      overruns <= overruns_next;
    end
  end

endmodule

@@ hw/rtl/flagged_slot_ring_buffer.sv @@
// Top level of the flagged slot ring buffer.
//
// Requests arrive on req: an operation (acquire, write, confirm, read) and a
// data word used by writes. Every request gives exactly one response on rsp:
// a status bit (set when a read finds no full slot), the word taken by a
// successful read or zero, the write slot after the operation and the
// running overrun count. The slot count is written on cfg, which is always
// ready; write it only while no request is in flight.
//
// A request is captured in an input register and processed from there into
// the response register when that register is empty or is being taken.
// The slot flags, pointers and data memory are updated as a request is
// processed, which sustains one request per cycle while rsp does not stall.
//
// When rsp stalls, the response register holds and one more request can
// wait in the input register; req.ready then falls until rsp moves again.
// Reset empties both registers, frees every slot, clears both pointers and
// the overrun count, and sets the slot count to sixteen.
module flagged_slot_ring_buffer import fsrb_pkg::*; #(
  parameter  int DEPTH      = DEPTH_DEF,
  parameter  int DATA_WIDTH = DATA_W_DEF,
  localparam int IDX_W      = $clog2(DEPTH)
) (
  input  logic      clk,
  input  logic      rst,
  fsrb_req_if.sink  req,
  fsrb_rsp_if.source rsp,
  fsrb_cfg_if.sink  cfg
);

  logic                  pend;
  fsrb_op_t              op_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic                  fire;
  fsrb_ctrl_t            ctrl;
  fsrb_stat_t            stat;
  logic [IDX_W-1:0]      wr_index;
  logic [IDX_W-1:0]      wr_index_next;
  logic [IDX_W-1:0]      rd_index_next;
  logic [OVR_W-1:0]      overruns_next;
  logic [DATA_WIDTH-1:0] rd_word;

  logic                  rsp_valid;
  logic                  status_q;
  logic [DATA_WIDTH-1:0] read_data_q;
  logic [IDX_W-1:0]      write_slot_q;
  logic [OVR_W-1:0]      overrun_q;

  assign fire      = pend && (!rsp_valid || rsp.ready);
  assign req.ready = !pend || fire;
  assign cfg.ready = 1'b1;

  assign ctrl.fire = fire;
  assign ctrl.op   = op_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (req.valid && req.ready) begin
      pend <= 1'b1;
    end else if (fire) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q   <= fsrb_op_t'(req.operation);
      data_q <= req.write_data;
    end
  end

  fsrb_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg.valid),
    .cfg_data     (cfg.slot_count),
    .ctrl         (ctrl),
    .stat         (stat),
    .wr_index     (wr_index),
    .wr_index_next(wr_index_next),
    .rd_index_next(rd_index_next),
    .overruns_next(overruns_next)
  );

  fsrb_store #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (fire && (op_q == OP_WRITE)),
    .wr_addr(wr_index),
    .wr_data(data_q),
    .rd_addr(rd_index_next),
    .rd_word(rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_q     <= stat.status;
      read_data_q  <= stat.read_ok ? rd_word : '0;
      write_slot_q <= wr_index_next;
      overrun_q    <= overruns_next;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = status_q;
  assign rsp.read_data     = read_data_q;
  assign rsp.write_slot    = write_slot_q;
  assign rsp.overrun_count = overrun_q;

endmodule

@@ hw/rtl/fsrb_checker.sv @@
// Port-level checks for the flagged slot ring buffer, bound to the top level.
module fsrb_checker import fsrb_pkg::*; #(
  parameter  int DEPTH      = DEPTH_DEF,
  parameter  int DATA_WIDTH = DATA_W_DEF,
  localparam int IDX_W      = $clog2(DEPTH)
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic                  rsp_status,
  input logic [DATA_WIDTH-1:0] rsp_read_data,
  input logic [IDX_W-1:0]      rsp_write_slot,
  input logic [OVR_W-1:0]      rsp_overrun_count
);

  // Reset leaves no response pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // An accepted request is followed by a pending response.
  a_accept_resp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |-> ##2 rsp_valid)
    else $error("accepted request produced no response");

  // A failed read never returns data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status) |-> (rsp_read_data == '0))
    else $error("error response carries read data");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
      $stable(rsp_read_data) && $stable(rsp_write_slot) && $stable(rsp_overrun_count)))
    else $error("stalled response changed");

endmodule

bind flagged_slot_ring_buffer fsrb_checker #(
  .DEPTH     (DEPTH),
  .DATA_WIDTH(DATA_WIDTH)
) u_fsrb_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_read_data    (rsp.read_data),
  .rsp_write_slot   (rsp.write_slot),
  .rsp_overrun_count(rsp.overrun_count)
);
